@@ src/epcr_pkg.sv @@
// Shared types and constants for the elastic pair collision response block.
`timescale 1ns / 1ps
`default_nettype none

package epcr_pkg;

   localparam int DIV_BITS = 50;
   localparam int DIV_LAT = DIV_BITS + 1;
   localparam int NUM_W = 131;
   localparam int DEN_W = 98;
   localparam int CMP_W = DEN_W + DIV_BITS;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int NST = DIV_LAT + 10;
   localparam int RST_W = 17;
   localparam logic [RST_W-1:0] RST_RESET = 17'd65536;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
      logic [30:0] ma;
      logic [30:0] mb;
   } item_type;

   typedef struct packed {
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
      logic pass;
      logic neg_x;
      logic neg_y;
   } side_type;

endpackage

`default_nettype wire

@@ src/elastic_pair_collision_response.sv @@
// Top level of the elastic pair collision response block.
`timescale 1ns / 1ps
`default_nettype none

// Takes one particle pair per beat and returns the post-impulse velocities,
// scaled by the restitution register and saturated, one result beat per pair.
// Throughput is one pair per clock while rsp_tready does not hold the output; a
// pair passes the front register, queue, product stages, 51-stage pipelined
// quotient divider, gain stages and result register. rsp_tuser is high when the
// impulse was applied and low when the centers coincide or both masses are zero
// (velocities pass through). Write restitution only while no pair is in flight.
module elastic_pair_collision_response import epcr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [RST_W-1:0] csr_wr_data,
   input  logic             req_tvalid,
   output logic             req_tready,
   // a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_vel_x, a_vel_y, b_vel_x, b_vel_y,
   // a_mass, b_mass, 2 zero bits
   input  logic [319:0]     req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // a_vel_x_out, a_vel_y_out, b_vel_x_out, b_vel_y_out
   output logic [127:0]     rsp_tdata,
   // applied
   output logic             rsp_tuser
);

   logic [RST_W-1:0] restitution_ff;
   logic             f_valid, q_ready, q_valid, q_pop;
   item_type         f_item, q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= RST_RESET;
      end else if (csr_wr_en) begin
         restitution_ff <= csr_wr_data;
      end
   end

   epcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (f_valid),
      .item_ready (q_ready),
      .item       (f_item)
   );

   epcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (q_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_en     (q_pop),
      .pop_item   (q_item)
   );

   epcr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .restitution (restitution_ff),
      .item_valid  (q_valid),
      .item_pop    (q_pop),
      .item        (q_item),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ src/epcr_front.sv @@
// Front stage: accept input beats and form the coordinate differences.
`timescale 1ns / 1ps
`default_nettype none

module epcr_front import epcr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [319:0] req_tdata,
   output logic         item_valid,
   input  logic         item_ready,
   output item_type     item
);

   logic     f_valid_ff, f_valid_in;
   item_type f_item_ff, f_item_in;
   logic     take;

   assign req_tready = !f_valid_ff || item_ready;
   assign take = req_tvalid && req_tready;

   always_comb begin
      f_item_in.dx  = 33'(signed'(req_tdata[31:0])) - 33'(signed'(req_tdata[95:64]));
      f_item_in.dy  = 33'(signed'(req_tdata[63:32])) - 33'(signed'(req_tdata[127:96]));
      f_item_in.dvx = 33'(signed'(req_tdata[159:128])) - 33'(signed'(req_tdata[223:192]));
      f_item_in.dvy = 33'(signed'(req_tdata[191:160])) - 33'(signed'(req_tdata[255:224]));
      f_item_in.vax = req_tdata[159:128];
      f_item_in.vay = req_tdata[191:160];
      f_item_in.vbx = req_tdata[223:192];
      f_item_in.vby = req_tdata[255:224];
      f_item_in.ma  = req_tdata[286:256];
      f_item_in.mb  = req_tdata[317:287];
      f_valid_in = take || (f_valid_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      if (take) begin
         f_item_ff <= f_item_in;
      end
   end

   assign item_valid = f_valid_ff;
   assign item = f_item_ff;

endmodule

`default_nettype wire

@@ src/epcr_queue.sv @@
// Short queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module epcr_queue import epcr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_en,
   output item_type pop_item
);

   item_type          mem_ff [0:QDEPTH-1];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QDEPTH);
   assign pop_valid = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop = pop_en && pop_valid;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ src/epcr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, quotient clamped.
`timescale 1ns / 1ps
`default_nettype none

module epcr_div import epcr_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [DIV_BITS:0] quot
);

   logic [NUM_W-1:0]    rem_ff   [0:DIV_BITS];
   logic [DEN_W-1:0]    den_ff   [0:DIV_BITS];
   logic [DIV_BITS-1:0] quo_ff   [0:DIV_BITS];
   logic                clamp_ff [0:DIV_BITS];
   logic                clamp_in;

   assign clamp_in = CMP_W'(num_in) >= {den_in, {DIV_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= num_in;
         den_ff[0] <= den_in;
         quo_ff[0] <= '0;
         clamp_ff[0] <= clamp_in;
      end
   end

   for (genvar k = 1; k <= DIV_BITS; k++) begin : g_stage
      localparam int B = DIV_BITS - k;
      logic [CMP_W-1:0] dsh, rext;
      logic             ge;
      assign dsh = CMP_W'(den_ff[k-1]) << B;
      assign rext = CMP_W'(rem_ff[k-1]);
      assign ge = rext >= dsh;
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= ge ? NUM_W'(rext - dsh) : rem_ff[k-1];
            quo_ff[k] <= quo_ff[k-1] | (ge ? (DIV_BITS'(1) << B) : '0);
            den_ff[k] <= den_ff[k-1];
            clamp_ff[k] <= clamp_ff[k-1];
         end
      end
   end

   assign quot = clamp_ff[DIV_BITS] ? {1'b1, {DIV_BITS{1'b0}}}
                                    : {1'b0, quo_ff[DIV_BITS]};

endmodule

`default_nettype wire

@@ src/epcr_back.sv @@
// Back part: impulse arithmetic, division, restitution gain and result register.
`timescale 1ns / 1ps
`default_nettype none

module epcr_back import epcr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [RST_W-1:0] restitution,
   input  logic             item_valid,
   output logic             item_pop,
   input  item_type         item,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [127:0]     rsp_tdata,
   output logic             rsp_tuser
);

   logic     adv;
   logic     valid_ff [0:NST-1];
   side_type side_ff  [0:NST-1];
   side_type side_in  [0:NST-1];

   // stage 1
   logic signed [65:0] p1_ff, p2_ff, q1_ff, q2_ff;
   logic [31:0]        msum_ff;
   logic signed [32:0] dx1_ff, dy1_ff;
   logic [30:0]        ma1_ff, mb1_ff;
   // stage 2
   logic signed [66:0] dot_ff;
   logic [65:0]        d2_ff;
   logic [31:0]        msum2_ff;
   logic signed [32:0] dx2_ff, dy2_ff;
   logic [30:0]        ma2_ff, mb2_ff;
   // stage 3
   logic signed [66:0] dmag;
   logic [66:0]        td_ff;
   logic [32:0]        dxm3_ff, dym3_ff;
   logic [64:0]        pl_ff, ph_ff;
   logic [30:0]        ma3_ff, mb3_ff;
   // stage 4
   logic [97:0]        den4_ff;
   logic [64:0]        tal_ff, tbl_ff;
   logic [63:0]        tah_ff, tbh_ff;
   logic [32:0]        dxm4_ff, dym4_ff;
   // stage 5
   logic [97:0]        den5_ff, ta_ff, tb_ff;
   logic [32:0]        dxm5_ff, dym5_ff;
   // stage 6
   logic [97:0]        den6_ff;
   logic [65:0]        pp0_ff [0:3];
   logic [65:0]        pp1_ff [0:3];
   logic [64:0]        pp2_ff [0:3];
   logic [97:0]        tsel [0:3];
   logic [32:0]        msel [0:3];
   // stage 7
   logic [97:0]        den7_ff;
   logic [NUM_W-1:0]   num_ff [0:3];
   // divider and gain
   logic [DIV_BITS:0]  quot [0:3];
   logic signed [52:0] t_ff [0:3];
   logic [51:0]        mag_ff [0:3];
   logic               neg2_ff [0:3];
   logic [68:0]        prod_ff [0:3];
   logic               neg3_ff [0:3];
   logic signed [31:0] sat [0:3];
   logic signed [31:0] raw [0:3];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [127:0]       rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign item_pop = adv;

   always_comb begin
      side_in[0].vax = item.vax;
      side_in[0].vay = item.vay;
      side_in[0].vbx = item.vbx;
      side_in[0].vby = item.vby;
      side_in[0].pass = 1'b0;
      side_in[0].neg_x = 1'b0;
      side_in[0].neg_y = 1'b0;
      for (int s = 1; s < NST; s++) begin
         side_in[s] = side_ff[s-1];
      end
      side_in[2].pass = (d2_ff == '0) || (msum2_ff == '0);
      side_in[2].neg_x = dot_ff[66] ^ dx2_ff[32];
      side_in[2].neg_y = dot_ff[66] ^ dy2_ff[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= item_valid;
         for (int s = 1; s < NST; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
      if (adv) begin
         for (int s = 0; s < NST; s++) begin
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign dmag = dot_ff[66] ? -dot_ff : dot_ff;

   always_comb begin
      tsel[0] = tb_ff; msel[0] = dxm5_ff;
      tsel[1] = tb_ff; msel[1] = dym5_ff;
      tsel[2] = ta_ff; msel[2] = dxm5_ff;
      tsel[3] = ta_ff; msel[3] = dym5_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= item.dvx * item.dx;
         p2_ff <= item.dvy * item.dy;
         q1_ff <= item.dx * item.dx;
         q2_ff <= item.dy * item.dy;
         msum_ff <= 32'(item.ma) + 32'(item.mb);
         dx1_ff <= item.dx;
         dy1_ff <= item.dy;
         ma1_ff <= item.ma;
         mb1_ff <= item.mb;

         dot_ff <= {p1_ff[65], p1_ff} + {p2_ff[65], p2_ff};
         d2_ff <= {1'b0, q1_ff[64:0]} + {1'b0, q2_ff[64:0]};
         msum2_ff <= msum_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         ma2_ff <= ma1_ff;
         mb2_ff <= mb1_ff;

         td_ff <= {dmag[65:0], 1'b0};
         dxm3_ff <= dx2_ff[32] ? 33'(-dx2_ff) : 33'(dx2_ff);
         dym3_ff <= dy2_ff[32] ? 33'(-dy2_ff) : 33'(dy2_ff);
         pl_ff <= d2_ff[32:0] * msum2_ff;
         ph_ff <= d2_ff[65:33] * msum2_ff;
         ma3_ff <= ma2_ff;
         mb3_ff <= mb2_ff;

         den4_ff <= 98'(pl_ff) + {ph_ff, 33'b0};
         tal_ff <= td_ff[33:0] * ma3_ff;
         tah_ff <= td_ff[66:34] * ma3_ff;
         tbl_ff <= td_ff[33:0] * mb3_ff;
         tbh_ff <= td_ff[66:34] * mb3_ff;
         dxm4_ff <= dxm3_ff;
         dym4_ff <= dym3_ff;

         den5_ff <= den4_ff;
         ta_ff <= 98'(tal_ff) + {tah_ff, 34'b0};
         tb_ff <= 98'(tbl_ff) + {tbh_ff, 34'b0};
         dxm5_ff <= dxm4_ff;
         dym5_ff <= dym4_ff;

         den6_ff <= den5_ff;
         for (int n = 0; n < 4; n++) begin
            pp0_ff[n] <= tsel[n][32:0] * msel[n];
            pp1_ff[n] <= tsel[n][65:33] * msel[n];
            pp2_ff[n] <= tsel[n][97:66] * msel[n];
         end

         den7_ff <= den6_ff;
         for (int n = 0; n < 4; n++) begin
            num_ff[n] <= NUM_W'(pp0_ff[n]) + NUM_W'({pp1_ff[n], 33'b0})
                         + {pp2_ff[n], 66'b0};
         end
      end
   end

   for (genvar n = 0; n < 4; n++) begin : g_div
      epcr_div u_div (
         .clock  (clock),
         .adv    (adv),
         .num_in (num_ff[n]),
         .den_in (den7_ff),
         .quot   (quot[n])
      );
   end

   // gain stages
   side_type sd;
   logic     negc [0:3];
   logic signed [52:0] corr [0:3];
   logic signed [52:0] vbase [0:3];
   logic [52:0] res [0:3];

   assign sd = side_ff[6+DIV_LAT];

   always_comb begin
      negc[0] = sd.neg_x; negc[1] = sd.neg_y;
      negc[2] = !sd.neg_x; negc[3] = !sd.neg_y;
      vbase[0] = 53'(sd.vax); vbase[1] = 53'(sd.vay);
      vbase[2] = 53'(sd.vbx); vbase[3] = 53'(sd.vby);
      for (int n = 0; n < 4; n++) begin
         corr[n] = negc[n] ? -53'(quot[n]) : 53'(quot[n]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 4; n++) begin
            t_ff[n] <= vbase[n] - corr[n];
            neg2_ff[n] <= t_ff[n][52];
            mag_ff[n] <= t_ff[n][52] ? 52'(-t_ff[n]) : 52'(t_ff[n]);
            neg3_ff[n] <= neg2_ff[n];
            prod_ff[n] <= mag_ff[n] * restitution;
         end
      end
   end

   always_comb begin
      raw[0] = side_ff[NST-1].vax;
      raw[1] = side_ff[NST-1].vay;
      raw[2] = side_ff[NST-1].vbx;
      raw[3] = side_ff[NST-1].vby;
      for (int n = 0; n < 4; n++) begin
         res[n] = prod_ff[n][68:16];
         if (neg3_ff[n]) begin
            sat[n] = (res[n] >= 53'h0_8000_0000) ? 32'sh8000_0000 : 32'(-res[n]);
         end else begin
            sat[n] = (res[n] > 53'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(res[n]);
         end
      end
      if (side_ff[NST-1].pass) begin
         rsp_data_in = {raw[3], raw[2], raw[1], raw[0]};
      end else begin
         rsp_data_in = {sat[3], sat[2], sat[1], sat[0]};
      end
      rsp_valid_in = adv ? valid_ff[NST-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= !side_ff[NST-1].pass;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

`default_nettype wire

@@ verif/elastic_pair_collision_response_checker.sv @@
// Checker for the collision response block: predicts each result beat and compares it.
`timescale 1ns / 1ps
`default_nettype none

module elastic_pair_collision_response_checker import epcr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [RST_W-1:0] csr_wr_data,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [319:0]     req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [127:0]     rsp_tdata,
   input  logic             rsp_tuser,
   output int               errors,
   output int               pending
);

   typedef logic signed [191:0] wide_t;

   logic [RST_W-1:0] gain_reg;
   logic [128:0]     velocity_queue[$];

   function automatic logic signed [63:0] scaled_quotient(wide_t num, wide_t den);
      wide_t q;
      wide_t lim;
      lim = wide_t'(1) <<< 50;
      q = num / den;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return q[63:0];
   endfunction

   function automatic logic [31:0] apply_gain(logic signed [63:0] t, logic [16:0] r);
      logic [63:0] mag;
      logic [63:0] rr;
      logic [63:0] res;
      mag = t[63] ? 64'(-t) : 64'(t);
      rr = {47'b0, r};
      res = rr * (mag >> 16) + ((rr * (mag & 64'hFFFF)) >> 16);
      if (t[63]) return (res >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-res);
      return (res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : res[31:0];
   endfunction

   function automatic logic [128:0] collide(logic [319:0] d, logic [16:0] r);
      wide_t dx, dy, vax, vay, vbx, vby, ma, mb, dot, d2, den, two_dot;
      logic [31:0] o0, o1, o2, o3;
      vax = wide_t'($signed(d[159:128]));
      vay = wide_t'($signed(d[191:160]));
      vbx = wide_t'($signed(d[223:192]));
      vby = wide_t'($signed(d[255:224]));
      dx = wide_t'($signed(d[31:0])) - wide_t'($signed(d[95:64]));
      dy = wide_t'($signed(d[63:32])) - wide_t'($signed(d[127:96]));
      ma = {161'b0, d[286:256]};
      mb = {161'b0, d[317:287]};
      dot = (vax - vbx) * dx + (vay - vby) * dy;
      d2 = dx * dx + dy * dy;
      if (d2 == 0 || ma + mb == 0)
         return {1'b0, d[255:128]};
      den = d2 * (ma + mb);
      two_dot = dot + dot;
      o0 = apply_gain(vax[63:0] - scaled_quotient(two_dot * mb * dx, den), r);
      o1 = apply_gain(vay[63:0] - scaled_quotient(two_dot * mb * dy, den), r);
      o2 = apply_gain(vbx[63:0] + scaled_quotient(two_dot * ma * dx, den), r);
      o3 = apply_gain(vby[63:0] + scaled_quotient(two_dot * ma * dy, den), r);
      return {1'b1, o3, o2, o1, o0};
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
      errors++;
   endtask

   initial begin
      errors = 0;
      pending = 0;
      gain_reg = RST_RESET;
   end

   always @(posedge clock) begin
      logic [128:0] want;
      if (reset) begin
         gain_reg <= RST_RESET;
      end else begin
         if (csr_wr_en) gain_reg <= csr_wr_data;
         if (req_tvalid && req_tready) velocity_queue.push_back(collide(req_tdata, gain_reg));
         if (rsp_tvalid && rsp_tready) begin
            if (velocity_queue.size() == 0) begin
               report_mismatch("unexpected beat", 32'h0, rsp_tdata[31:0]);
            end else begin
               want = velocity_queue.pop_front();
               if (want[31:0] !== rsp_tdata[31:0])
                  report_mismatch("a_vel_x_out", want[31:0], rsp_tdata[31:0]);
               if (want[63:32] !== rsp_tdata[63:32])
                  report_mismatch("a_vel_y_out", want[63:32], rsp_tdata[63:32]);
               if (want[95:64] !== rsp_tdata[95:64])
                  report_mismatch("b_vel_x_out", want[95:64], rsp_tdata[95:64]);
               if (want[127:96] !== rsp_tdata[127:96])
                  report_mismatch("b_vel_y_out", want[127:96], rsp_tdata[127:96]);
               if (want[128] !== rsp_tuser)
                  report_mismatch("applied", {31'b0, want[128]}, {31'b0, rsp_tuser});
            end
         end
      end
      pending <= velocity_queue.size();
   end

endmodule

`default_nettype wire

@@ verif/elastic_pair_collision_response_tb.sv @@
// Top of the collision response testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none

module elastic_pair_collision_response_tb import epcr_pkg::*;;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [RST_W-1:0] csr_wr_data = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [319:0]     req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [127:0]     rsp_tdata;
   logic             rsp_tuser;
   int               errors;
   int               pending;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;

   elastic_pair_collision_response dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   elastic_pair_collision_response_checker chk (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .errors(errors), .pending(pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("status: fail");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [319:0] pack_pair(logic [31:0] apx, logic [31:0] apy,
         logic [31:0] bpx, logic [31:0] bpy, logic [31:0] avx, logic [31:0] avy,
         logic [31:0] bvx, logic [31:0] bvy, logic [30:0] ma, logic [30:0] mb);
      return {2'b00, mb, ma, bvy, bvx, avy, avx, bpy, bpx, apy, apx};
   endfunction

   task automatic send_beat(logic [319:0] d);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom};
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_and_write(logic [RST_W-1:0] value);
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (DIV_LAT + 20) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      csr_wr_data = RST_W'($urandom);
   endtask

   function automatic logic [30:0] rand_mass();
      logic [30:0] m;
      case ($urandom_range(3))
         0: m = 31'($urandom_range(255));
         1: m = 31'($urandom_range(32'h0004_0000, 32'h0000_4000));
         default: m = 31'($urandom);
      endcase
      return (m == 0) ? 31'd1 : m;
   endfunction

   function automatic logic [319:0] random_pair();
      logic [31:0] apx, apy, bpx, bpy, ofs;
      apx = $urandom;
      apy = $urandom;
      case ($urandom_range(9))
         0: begin
            bpx = apx;
            bpy = apy;
         end
         1, 2: begin
            bpx = $urandom;
            bpy = $urandom;
         end
         default: begin
            ofs = $urandom_range(32'h0004_0000);
            bpx = apx + ($urandom_range(1) ? ofs : -ofs);
            ofs = $urandom_range(32'h0004_0000);
            bpy = apy + ($urandom_range(1) ? ofs : -ofs);
         end
      endcase
      return pack_pair(apx, apy, bpx, bpy, $urandom, $urandom, $urandom, $urandom,
                       rand_mass(), rand_mass());
   endfunction

   localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SMIN = 32'h8000_0000;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [30:0] MMAX = 31'h7FFF_FFFF;

   initial begin
      logic [RST_W-1:0] gains[4];
      int sends[4];
      int idles[4];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_beat(pack_pair(0, 0, ONE, 0, ONE, 0, 0, 0, ONE[30:0], ONE[30:0]));
      send_beat(pack_pair(0, 0, 0, 0, ONE, SMIN, SMAX, 5, ONE[30:0], 1));
      send_beat(pack_pair(SMAX, SMAX, SMIN, SMIN, SMAX, SMAX, SMIN, SMIN, MMAX, MMAX));
      send_beat(pack_pair(SMIN, SMIN, SMAX, SMAX, SMIN, SMIN, SMAX, SMAX, 1, 1));
      send_beat(pack_pair(0, 0, 1, 0, SMAX, SMIN, SMIN, SMAX, 1, MMAX));
      send_beat(pack_pair(0, 0, 0, 1, SMIN, SMAX, SMAX, SMIN, MMAX, 1));
      send_beat(pack_pair(ONE, ONE, 0, 0, 0, 0, 0, 0, ONE[30:0], ONE[30:0]));
      send_beat(pack_pair(SMAX, 0, SMAX, 0, SMAX, SMIN, 0, 0, MMAX, MMAX));
      send_beat(pack_pair(0, SMIN, 0, SMAX, -ONE, ONE, ONE, -ONE, 3, 7));
      send_beat(pack_pair(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
                          32'hFFFF_FFFF, 1, 1));
      for (int i = 0; i < 8; i++) send_beat(random_pair());

      gains[0] = 17'd0;
      gains[1] = 17'd65535;
      gains[2] = RST_RESET;
      gains[3] = RST_W'($urandom_range(65536));
      sends[0] = 0;  idles[0] = 0;
      sends[1] = 84; idles[1] = 0;
      sends[2] = 0;  idles[2] = 84;
      sends[3] = 13; idles[3] = 13;
      for (int p = 0; p < 4; p++) begin
         drain_and_write(gains[p]);
         send_idle_pct = sends[p];
         recv_stall_pct = idles[p];
         for (int i = 0; i < 430; i++) begin
            if (p == 2 && i == 200) begin
               @(negedge clock);
               req_tvalid = 1'b0;
               wait (pending == 0);
            end
            send_beat(random_pair());
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      recv_stall_pct = 0;
      wait (pending == 0);
      repeat (NST + 20) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
src/epcr_pkg.sv
src/epcr_front.sv
src/epcr_queue.sv
src/epcr_div.sv
src/epcr_back.sv
src/elastic_pair_collision_response.sv
verif/elastic_pair_collision_response_checker.sv
verif/elastic_pair_collision_response_tb.sv
